/* hdl/mx2p_pkg.sv */
// Shared types and constants for the 2x2 matrix power block.
`default_nettype none

package mx2p_pkg;

   localparam int WordWidth = 32;
   localparam int ExpWidth  = 31;
   localparam int StepWidth = 4;

   // step counter inside one matrix multiply: products issued on steps 0..7,
   // last sum written on step 8, result committed on step 9
   localparam logic [StepWidth-1:0] IssueLast = 4'd7;
   localparam logic [StepWidth-1:0] StepLast  = 4'd9;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [3:0]       mat_type;   // row-major: {row, col}
   typedef logic [ExpWidth-1:0]  exp_type;
   typedef logic [StepWidth-1:0] step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC_MUL,
      ST_SQR_MUL,
      ST_RESPOND
   } state_type;

   // sequencer to datapath
   typedef struct packed {
      logic       busy;
      logic       load;         // take the input matrix into acc and base
      logic       issue;        // one product enters the multiplier
      logic       use_acc;      // left operand is acc (else base)
      logic [2:0] idx;          // {row, col, term}
      logic       commit_acc;   // acc <= product matrix
      logic       commit_base;  // base <= product matrix
      logic       respond;
   } ctrl_type;

endpackage

`default_nettype wire

/* hdl/mx2p_mac.sv */
// Shared multiply-accumulate unit: one 32x32 product per cycle, sums into a temp matrix.
`default_nettype none

module mx2p_mac (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    issue,
   input  wire [2:0]              idx,
   input  mx2p_pkg::word_type     op_a,
   input  mx2p_pkg::word_type     op_b,
   output mx2p_pkg::mat_type      product
);
   import mx2p_pkg::*;

   logic [2*WordWidth-1:0] full_prod;
   word_type               prod_ff;
   logic                   prod_valid_ff;
   logic [2:0]             prod_idx_ff;
   word_type               sum_ff;
   mat_type                temp_ff;

   // only the low word survives: wraps modulo 2^32
   assign full_prod = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= full_prod[WordWidth-1:0];
      prod_idx_ff <= idx;
      if (prod_valid_ff) begin
         if (!prod_idx_ff[0]) begin
            sum_ff <= prod_ff;
         end else begin
            temp_ff[prod_idx_ff[2:1]] <= sum_ff + prod_ff;
         end
      end
   end

   assign product = temp_ff;

endmodule

`default_nettype wire

/* hdl/mx2p_ctrl.sv */
// Sequencer: walks the exponent bits and steps the shared unit through each multiply.
`default_nettype none

module mx2p_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  mx2p_pkg::exp_type   exponent,
   output mx2p_pkg::ctrl_type  ctrl
);
   import mx2p_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   exp_type   exp_ff, exp_in;
   exp_type   exp_shift;

   assign exp_shift = exp_ff >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         exp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         exp_ff   <= exp_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      exp_in   = exp_ff;
      ctrl     = '0;
      ctrl.busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (start) begin
               ctrl.load = 1'b1;
               if (exponent == '0) begin
                  state_in = ST_RESPOND;
               end else if (exponent[0]) begin
                  exp_in   = exponent;
                  state_in = ST_ACC_MUL;
               end else begin
                  exp_in   = exponent >> 1;
                  state_in = ST_SQR_MUL;
               end
            end
         end
         ST_ACC_MUL, ST_SQR_MUL: begin
            ctrl.issue   = (step_ff <= IssueLast);
            ctrl.use_acc = (state_ff == ST_ACC_MUL);
            ctrl.idx     = step_ff[2:0];
            step_in      = step_ff + 4'd1;
            if (step_ff == StepLast) begin
               step_in = '0;
               if (state_ff == ST_ACC_MUL) begin
                  ctrl.commit_acc = 1'b1;
                  if (exp_shift != '0) begin
                     exp_in   = exp_shift;
                     state_in = ST_SQR_MUL;
                  end else begin
                     state_in = ST_RESPOND;
                  end
               end else begin
                  ctrl.commit_base = 1'b1;
                  if (exp_ff[0]) begin
                     state_in = ST_ACC_MUL;
                  end else begin
                     exp_in   = exp_shift;
                     state_in = ST_SQR_MUL;
                  end
               end
            end
         end
         ST_RESPOND: begin
            ctrl.respond = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/matrix_2x2_power.sv */
// Top level: 2x2 matrix raised to the power e+1 by square-and-multiply, 32-bit wrapping.
// For e = 0 the input matrix is returned with no multiply; else popcount(e) accumulate and
//   floor(log2(e)) squaring multiplies run between the start transfer and the rsp_valid strobe.
// Each 2x2 multiply runs on the one shared 32x32 multiplier (8 products, drain, commit).
// A new start is taken only once idle; busy drops the cycle after rsp_valid.
// The receiver cannot stall. Sync active-high reset idles the sequencer; data regs not cleared.
`default_nettype none

module matrix_2x2_power (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire signed [31:0]   req_entry_00,
   input  wire signed [31:0]   req_entry_01,
   input  wire signed [31:0]   req_entry_10,
   input  wire signed [31:0]   req_entry_11,
   input  wire [30:0]          req_exponent,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_result_00,
   output logic signed [31:0]  rsp_result_01,
   output logic signed [31:0]  rsp_result_10,
   output logic signed [31:0]  rsp_result_11
);
   import mx2p_pkg::*;

   ctrl_type ctrl;
   mat_type  acc_ff;      // running product
   mat_type  base_ff;     // base, squared once per exponent bit above bit 0
   mat_type  product;     // result of the last multiply from the shared unit
   mat_type  left_op;
   word_type op_a;
   word_type op_b;

   mx2p_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .exponent (req_exponent),
      .ctrl     (ctrl)
   );

   // Operand select for one product term.
   // idx = {row, col, term}: left = P[row][term], right = base[term][col].
   assign left_op = ctrl.use_acc ? acc_ff : base_ff;
   assign op_a    = left_op[{ctrl.idx[2], ctrl.idx[0]}];
   assign op_b    = base_ff[{ctrl.idx[0], ctrl.idx[1]}];

   mx2p_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .issue   (ctrl.issue),
      .idx     (ctrl.idx),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // Working matrices: both start as the input matrix; each multiply commits
   // its whole product at once, so operands stay stable while it runs.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         acc_ff  <= {$unsigned(req_entry_11), $unsigned(req_entry_10),
                     $unsigned(req_entry_01), $unsigned(req_entry_00)};
         base_ff <= {$unsigned(req_entry_11), $unsigned(req_entry_10),
                     $unsigned(req_entry_01), $unsigned(req_entry_00)};
      end else begin
         if (ctrl.commit_acc) begin
            acc_ff <= product;
         end
         if (ctrl.commit_base) begin
            base_ff <= product;
         end
      end
   end

   assign busy          = ctrl.busy;
   assign rsp_valid     = ctrl.respond;
   assign rsp_result_00 = $signed(acc_ff[0]);
   assign rsp_result_01 = $signed(acc_ff[1]);
   assign rsp_result_10 = $signed(acc_ff[2]);
   assign rsp_result_11 = $signed(acc_ff[3]);

`ifndef SYNTHESIS
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after start transfer");

   a_rsp_in_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a busy period");

   a_zero_exp : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_exponent == '0) |=> rsp_valid)
      else $error("zero exponent did not respond on the next cycle");

   a_commit_excl : assert property (@(posedge clock) disable iff (reset)
      !(ctrl.commit_acc && ctrl.commit_base) && !(ctrl.load && ctrl.issue))
      else $error("conflicting datapath controls");
`endif

endmodule

`default_nettype wire
